// ----- src/line_position_calibrated_sensors_unit_assert.svh -----
`ifndef LINE_POSITION_CALIBRATED_SENSORS_UNIT_ASSERT_SVH
`define LINE_POSITION_CALIBRATED_SENSORS_UNIT_ASSERT_SVH
// implication checked at every clock edge outside reset
`define LPCS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define LPCS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ----- src/lpcs_pkg.sv -----
package lpcs_pkg;
	localparam int SENSOR_COUNT_DEF = 8;
	localparam int CAL_FRAMES_DEF = 10;
	localparam logic [9:0] FULL_SCALE = 10'd1023;
	localparam logic [1:0] MODE_LIT = 2'd0;
	localparam logic [1:0] MODE_DARK = 2'd1;
	localparam logic [1:0] STAT_VALID = 2'd0;
	localparam logic [1:0] STAT_UNCAL = 2'd1;
	localparam logic [1:0] STAT_CAL = 2'd2;
	localparam logic [0:0] REG_READ_MODE = 1'd0;
	localparam logic [0:0] REG_WHITE_LINE = 1'd1;
endpackage

// ----- src/lpcs_ram.sv -----
module lpcs_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ----- src/line_position_calibrated_sensors_unit.sv -----
// A result follows the transfer that ends a line frame (with or without the position
// divide) or a calibration frame (after a bound sweep when that frame closes a round).
// A line reading does read, setup, a 21-step restoring divide and accumulate, a calibration
// reading read, round update and accumulate. A transfer is taken only in idle, so input is
// held while a reading or result is pending. Closing a round sweeps the bound memory.
// Reset (arst_n low, async): bounds read as lows 1023, highs 0; counters, sums, flags cleared.
module line_position_calibrated_sensors_unit #(
	parameter int SENSOR_COUNT = lpcs_pkg::SENSOR_COUNT_DEF,
	parameter int CAL_FRAMES = lpcs_pkg::CAL_FRAMES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // sensor_index[2:0], value_on[12:3], value_off[22:13]
	input  logic        s_tuser,   // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // position[12:0], on_line[13], status[15:14]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [1:0]  cfg_data
);
	import lpcs_pkg::*;

	localparam int AW = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
	localparam logic [12:0] TOP = 13'((SENSOR_COUNT - 1) * 1000);
	localparam logic [3:0] LAST_ROUND = 4'(CAL_FRAMES - 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_READ = 3'd1;
	localparam logic [2:0] ST_CALC = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_ACC  = 3'd4;
	localparam logic [2:0] ST_PDIV = 3'd5;
	localparam logic [2:0] ST_SWEEP = 3'd6;
	localparam logic [2:0] ST_OUT  = 3'd7;

	logic [2:0] state_q;
	logic [1:0] read_mode_q;
	logic       white_line_q;
	logic       op_q;
	logic [2:0] idx_q;
	logic [9:0] von_q, voff_q;
	logic [3:0] round_count_q;
	logic       lit_cal_q, dark_cal_q;
	logic [25:0] wtot_q;
	logic [12:0] vtot_q;
	logic        seen_q;
	logic [12:0] last_pos_q;
	logic [SENSOR_COUNT-1:0] cvalid_q;
	logic [AW:0] sweep_q;

	// divider
	logic [25:0] quo_q;
	logic [25:0] rem_q;
	logic [12:0] den_q;
	logic [4:0]  cnt_q;
	logic        zero_q;

	// memories: cal = {hd, ld, hl, ll}, round = {hd, ld, hl, ll}
	logic            cal_we, rnd_we;
	logic [AW-1:0]   cal_waddr, cal_raddr, rnd_raddr;
	logic [39:0]     cal_wdata, cal_rdata, rnd_wdata, rnd_rdata;

	lpcs_ram #(.WIDTH(40), .DEPTH(SENSOR_COUNT)) u_cal (
		.clk(clk), .we(cal_we), .waddr(cal_waddr), .wdata(cal_wdata),
		.raddr(cal_raddr), .rdata(cal_rdata)
	);
	lpcs_ram #(.WIDTH(40), .DEPTH(SENSOR_COUNT)) u_round (
		.clk(clk), .we(rnd_we), .waddr(idx_q[AW-1:0]), .wdata(rnd_wdata),
		.raddr(rnd_raddr), .rdata(rnd_rdata)
	);

	logic [AW-1:0] sweep_addr;
	assign sweep_addr = sweep_q[AW-1:0];
	assign cal_raddr = (state_q == ST_SWEEP) ? sweep_addr : idx_q[AW-1:0];
	assign rnd_raddr = cal_raddr;

	// reset view of the cal memory
	logic        cv_rd;
	logic [AW-1:0] cv_idx;
	logic [9:0]  ll, hl, ld, hd;
	always_comb begin
		cv_idx = cal_raddr;
		cv_rd = cvalid_q[cv_idx];
	end
	logic cv_rd_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cv_rd_s1 <= 1'b0;
		else cv_rd_s1 <= cv_rd;
	end
	assign ll = cv_rd_s1 ? cal_rdata[9:0]   : FULL_SCALE;
	assign hl = cv_rd_s1 ? cal_rdata[19:10] : 10'd0;
	assign ld = cv_rd_s1 ? cal_rdata[29:20] : FULL_SCALE;
	assign hd = cv_rd_s1 ? cal_rdata[39:30] : 10'd0;

	function automatic logic [10:0] comb_b(input logic [9:0] l, input logic [9:0] d);
		comb_b = (d < l) ? 11'd1023 : 11'({1'b0, l} + 11'd1023 - {1'b0, d});
	endfunction

	// scale operands
	logic [10:0] r_c, lo_c, hi_c;
	always_comb begin
		unique case (read_mode_q)
			MODE_LIT: begin
				r_c = {1'b0, von_q}; lo_c = {1'b0, ll}; hi_c = {1'b0, hl};
			end
			MODE_DARK: begin
				r_c = {1'b0, voff_q}; lo_c = {1'b0, ld}; hi_c = {1'b0, hd};
			end
			default: begin
				r_c = 11'({1'b0, von_q} + 11'd1023 - {1'b0, voff_q});
				lo_c = comb_b(ll, ld);
				hi_c = comb_b(hl, hd);
			end
		endcase
	end

	// round update
	logic [9:0] rll, rhl, rld, rhd;
	always_comb begin
		if (round_count_q == 4'd0) begin
			rll = von_q; rhl = von_q; rld = voff_q; rhd = voff_q;
		end else begin
			rll = (von_q < rnd_rdata[9:0]) ? von_q : rnd_rdata[9:0];
			rhl = (von_q > rnd_rdata[19:10]) ? von_q : rnd_rdata[19:10];
			rld = (voff_q < rnd_rdata[29:20]) ? voff_q : rnd_rdata[29:20];
			rhd = (voff_q > rnd_rdata[39:30]) ? voff_q : rnd_rdata[39:30];
		end
	end
	assign rnd_wdata = {rhd, rld, rhl, rll};
	assign rnd_we = (state_q == ST_CALC) && op_q;

	// widening sweep
	logic use_lit, use_dark;
	assign use_lit = (read_mode_q != MODE_DARK);
	assign use_dark = (read_mode_q != MODE_LIT);
	logic [9:0] nll, nhl, nld, nhd;
	always_comb begin
		nll = ll; nhl = hl; nld = ld; nhd = hd;
		if (use_lit) begin
			if (rnd_rdata[9:0] > hl) nhl = rnd_rdata[9:0];
			if (rnd_rdata[19:10] < ll) nll = rnd_rdata[19:10];
		end
		if (use_dark) begin
			if (rnd_rdata[29:20] > hd) nhd = rnd_rdata[29:20];
			if (rnd_rdata[39:30] < ld) nld = rnd_rdata[39:30];
		end
	end
	logic [AW:0] sweep_prev;
	assign sweep_prev = sweep_q - 1'b1;
	assign cal_we = (state_q == ST_SWEEP) && (sweep_q != '0);
	assign cal_waddr = sweep_prev[AW-1:0];
	assign cal_wdata = {nhd, nld, nhl, nll};

	// scaled value after divide
	logic [10:0] q_sat, v_c;
	assign q_sat = (quo_q > 26'd1000) ? 11'd1000 : quo_q[10:0];
	always_comb begin
		v_c = zero_q ? 11'd0 : q_sat;
		if (white_line_q) v_c = 11'd1000 - v_c;
	end

	logic [25:0] rem_sh;
	logic [25:0] sub_c;
	assign rem_sh = {rem_q[24:0], quo_q[25]};
	assign sub_c = rem_sh - {13'd0, den_q};

	// scale dividend, up to 2046 * 1000 in mode 2: 21 bits
	logic [25:0] prod_c;
	assign prod_c = {15'd0, 11'(r_c - lo_c)} * 26'd1000;

	logic s_acc;
	assign s_acc = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);

	logic [12:0] pos_q;
	logic        online_q;
	logic [1:0]  status_q;
	assign m_tdata = {status_q, online_q, pos_q};

	logic last_c;
	assign last_c = (idx_q == 3'(SENSOR_COUNT - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			read_mode_q <= 2'd0;
			white_line_q <= 1'b0;
			round_count_q <= 4'd0;
			lit_cal_q <= 1'b0;
			dark_cal_q <= 1'b0;
			wtot_q <= '0;
			vtot_q <= '0;
			seen_q <= 1'b0;
			last_pos_q <= '0;
			cvalid_q <= '0;
			sweep_q <= '0;
			op_q <= 1'b0;
			idx_q <= '0;
			von_q <= '0;
			voff_q <= '0;
			quo_q <= '0;
			rem_q <= '0;
			den_q <= '0;
			cnt_q <= '0;
			zero_q <= 1'b0;
			pos_q <= '0;
			online_q <= 1'b0;
			status_q <= STAT_VALID;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cfg_valid) begin
						if (cfg_index == REG_READ_MODE) read_mode_q <= cfg_data;
						else white_line_q <= cfg_data[0];
					end
					if (s_acc && (5'(s_tdata[2:0]) < 5'(SENSOR_COUNT))) begin
						op_q <= s_tuser;
						idx_q <= s_tdata[2:0];
						von_q <= s_tdata[12:3];
						voff_q <= s_tdata[22:13];
						state_q <= ST_READ;
					end
				end
				ST_READ: state_q <= ST_CALC;
				ST_CALC: begin
					if (op_q) begin
						state_q <= ST_ACC;
					end else begin
						zero_q <= (hi_c <= lo_c) || (r_c <= lo_c);
						quo_q <= prod_c << 5;
						rem_q <= '0;
						den_q <= {2'd0, 11'(hi_c - lo_c)};
						cnt_q <= 5'd21;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (sub_c[25] == 1'b0) begin
						rem_q <= sub_c;
						quo_q <= {quo_q[24:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						quo_q <= {quo_q[24:0], 1'b0};
					end
					if (cnt_q == 5'd1) state_q <= ST_ACC;
					cnt_q <= cnt_q - 1'b1;
				end
				ST_ACC: begin
					logic [12:0] vt;
					logic [25:0] wt;
					logic        sn;
					vt = vtot_q; wt = wtot_q; sn = seen_q;
					if (!op_q) begin
						if (v_c > 11'd200) sn = 1'b1;
						if (v_c > 11'd50) begin
							vt = vtot_q + 13'(v_c);
							wt = wtot_q + 26'(v_c * 13'(idx_q) * 10'd1000);
						end
					end
					if (!last_c) begin
						vtot_q <= vt; wtot_q <= wt; seen_q <= sn;
						state_q <= ST_IDLE;
					end else begin
						vtot_q <= '0; wtot_q <= '0; seen_q <= 1'b0;
						pos_q <= '0; online_q <= 1'b0;
						if (op_q) begin
							status_q <= STAT_CAL;
							if (round_count_q == LAST_ROUND) begin
								round_count_q <= 4'd0;
								sweep_q <= '0;
								state_q <= ST_SWEEP;
							end else begin
								round_count_q <= round_count_q + 1'b1;
								state_q <= ST_OUT;
							end
						end else if ((use_lit && !lit_cal_q) || (use_dark && !dark_cal_q)) begin
							status_q <= STAT_UNCAL;
							state_q <= ST_OUT;
						end else begin
							status_q <= STAT_VALID;
							online_q <= sn;
							if (!sn) begin
								pos_q <= (last_pos_q < (TOP >> 1)) ? 13'd0 : TOP;
								state_q <= ST_OUT;
							end else if (vt == '0) begin
								last_pos_q <= '0;
								state_q <= ST_OUT;
							end else begin
								quo_q <= wt;
								rem_q <= '0;
								den_q <= vt;
								cnt_q <= 5'd26;
								state_q <= ST_PDIV;
							end
						end
					end
				end
				ST_PDIV: begin
					if (sub_c[25] == 1'b0) begin
						rem_q <= sub_c;
						quo_q <= {quo_q[24:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						quo_q <= {quo_q[24:0], 1'b0};
					end
					if (cnt_q == 5'd1) begin
						pos_q <= {quo_q[11:0], ~sub_c[25]};
						last_pos_q <= {quo_q[11:0], ~sub_c[25]};
						state_q <= ST_OUT;
					end
					cnt_q <= cnt_q - 1'b1;
				end
				ST_SWEEP: begin
					// read row sweep_q while writing row sweep_q-1
					if (sweep_q != '0) cvalid_q[sweep_prev[AW-1:0]] <= 1'b1;
					if (sweep_q == (AW+1)'(SENSOR_COUNT)) begin
						if (use_lit) lit_cal_q <= 1'b1;
						if (use_dark) dark_cal_q <= 1'b1;
						state_q <= ST_OUT;
					end
					sweep_q <= sweep_q + 1'b1;
				end
				ST_OUT: if (m_tready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`include "line_position_calibrated_sensors_unit_assert.svh"
	`LPCS_ASSERT_IMP(a_out_idle, m_tvalid, !s_tready)
	`LPCS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`LPCS_ASSERT_IMP(a_pos_range, m_tvalid, m_tdata[12:0] <= TOP)
	`LPCS_ASSERT_IMP(a_cal_status, m_tvalid && m_tdata[15:14] == STAT_CAL, m_tdata[13:0] == '0)
endmodule
